// ===== rtl/binary_to_decimal_ascii_macros.svh =====
// Assertion macros for the binary to decimal ASCII renderer
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication, checked outside reset
`define B2DA_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define B2DA_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/b2da_pkg.sv =====
// Constants and digit adjust function for the binary to decimal ASCII renderer
`default_nettype none

package b2da_pkg;

    localparam int VALUE_W    = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int BCD_W      = DIGIT_W * NUM_DIGITS;
    localparam int CHAR_W     = 6;
    localparam int CNT_W      = $clog2(VALUE_W);
    localparam int DIG_CNT_W  = $clog2(NUM_DIGITS + 1);

    localparam logic [CHAR_W-1:0]  ASCII_ZERO = CHAR_W'(48);
    localparam logic [DIGIT_W-1:0] ADJ_LIMIT  = DIGIT_W'(5);
    localparam logic [DIGIT_W-1:0] ADJ_ADD    = DIGIT_W'(3);

    typedef logic [BCD_W-1:0] bcd_t;

    function automatic logic [DIGIT_W-1:0] dabble_adj(input logic [DIGIT_W-1:0] d);
        logic [DIGIT_W-1:0] r;
        r = (d >= ADJ_LIMIT) ? d + ADJ_ADD : d;
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/binary_to_decimal_ascii.sv =====
// Binary to decimal ASCII renderer: shift-and-add-3 conversion, then digit emission
//
//   channel | ports                             | direction
//   --------+-----------------------------------+----------
//   input   | s_valid s_ready s_value[31:0]     | in
//   result  | m_valid m_ready m_digit_char[5:0] | out
//           | m_last_digit                      |
//
// One item goes through conversion in a ten-digit add-3/shift unit, then
// leading zeros are skipped and digits are emitted, one digit per cycle when
// m_ready is high.
// s_ready is high only while idle; a stall on m_ready holds the current digit.
// aresetn is synchronous and active low and returns the block to idle.
`default_nettype none

module binary_to_decimal_ascii (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic [b2da_pkg::VALUE_W-1:0]  s_value,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic [b2da_pkg::CHAR_W-1:0]        m_digit_char,
    output logic                               m_last_digit
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_SKIP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam int DW = b2da_pkg::DIGIT_W;
    localparam int BW = b2da_pkg::BCD_W;

    logic [1:0]                         state_reg, state_next;
    logic [b2da_pkg::CNT_W-1:0]         cnt_reg, cnt_next;
    logic [b2da_pkg::DIG_CNT_W-1:0]     dig_reg, dig_next;
    logic [b2da_pkg::VALUE_W-1:0]       bin_reg, bin_next;
    b2da_pkg::bcd_t                     bcd_reg, bcd_next;
    b2da_pkg::bcd_t                     adj;
    logic [DW-1:0]                      top_digit;
    logic                               s_fire, m_fire;

    assign top_digit    = bcd_reg[BW-1 -: DW];
    assign s_ready      = (state_reg == ST_IDLE);
    assign m_valid      = (state_reg == ST_EMIT);
    assign m_digit_char = b2da_pkg::ASCII_ZERO + {{(b2da_pkg::CHAR_W-DW){1'b0}}, top_digit};
    assign m_last_digit = (dig_reg == b2da_pkg::DIG_CNT_W'(1));
    assign s_fire       = s_valid && s_ready;
    assign m_fire       = m_valid && m_ready;

    always_comb begin
        for (int i = 0; i < b2da_pkg::NUM_DIGITS; i++) begin
            adj[i*DW +: DW] = b2da_pkg::dabble_adj(bcd_reg[i*DW +: DW]);
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        dig_next   = dig_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_fire) begin
                    bin_next   = s_value;
                    bcd_next   = '0;
                    cnt_next   = b2da_pkg::CNT_W'(b2da_pkg::VALUE_W - 1);
                    dig_next   = b2da_pkg::DIG_CNT_W'(b2da_pkg::NUM_DIGITS);
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                bcd_next = {adj[BW-2:0], bin_reg[b2da_pkg::VALUE_W-1]};
                bin_next = {bin_reg[b2da_pkg::VALUE_W-2:0], 1'b0};
                cnt_next = cnt_reg - b2da_pkg::CNT_W'(1);
                if (cnt_reg == '0) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                if ((top_digit == '0) && !m_last_digit) begin
                    bcd_next = {bcd_reg[BW-DW-1:0], {DW{1'b0}}};
                    dig_next = dig_reg - b2da_pkg::DIG_CNT_W'(1);
                end else begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (m_fire) begin
                    if (m_last_digit) begin
                        state_next = ST_IDLE;
                    end else begin
                        bcd_next = {bcd_reg[BW-DW-1:0], {DW{1'b0}}};
                        dig_next = dig_reg - b2da_pkg::DIG_CNT_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
            dig_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            dig_reg   <= dig_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

`include "binary_to_decimal_ascii_macros.svh"

    `B2DA_ASSERT_NOW(a_one_side, 1'b1, !(s_ready && m_valid), "ready while emitting")
    `B2DA_ASSERT_NEXT(a_busy_after_accept, s_fire, !s_ready && !m_valid, "item not held busy")
    `B2DA_ASSERT_NEXT(a_idle_after_last, m_fire && m_last_digit, s_ready && !m_valid,
        "no return to idle after last digit")
    `B2DA_ASSERT_NOW(a_digit_range, m_valid, top_digit <= 4'd9, "digit out of decimal range")

endmodule

`default_nettype wire
